// ===== hw/rtl/fbfl_pkg.sv =====
package fbfl_pkg;

	// request action codes
	typedef enum logic [2:0] {
		ACT_INIT     = 3'd0,
		ACT_ALLOC    = 3'd1,
		ACT_FREE     = 3'd2,
		ACT_RELEASE  = 3'd3,
		ACT_TEARDOWN = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_EMPTY       = 3'd1,
		STS_REFUSED     = 3'd2,
		STS_NONE_IN_USE = 3'd3,
		STS_STILL_USED  = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_INIT = 3'b100
	} state_t;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned COUNT_W  = 11;

	// one result as handed from the sequencer to the output register
	typedef struct packed {
		status_t              status;
		logic [INDEX_W-1:0]   granted_index;
		logic [COUNT_W-1:0]   used_count;
		logic                 all_free;
	} result_t;

endpackage

// ===== hw/rtl/fbfl_ram.sv =====
module fbfl_ram #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/fbfl_ctrl.sv =====
module fbfl_ctrl
	import fbfl_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ACTION_W-1:0]               in_action,
	input  logic [INDEX_W-1:0]                in_index,
	input  logic [COUNT_W-1:0]                block_count,
	output logic                              push,
	input  logic                              res_ready,
	output result_t                           res,
	output logic                              ram_wr_en,
	output logic [$clog2(MAX_BLOCKS)-1:0]     ram_wr_addr,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]   ram_wr_data,
	output logic [$clog2(MAX_BLOCKS)-1:0]     ram_rd_addr,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]   ram_rd_data
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] NULL_LINK = CW'(MAX_BLOCKS);

	state_t          state_q, state_d;
	action_t         act_q;
	logic [INDEX_W-1:0] idx_q;
	logic [CW-1:0]   head_q, head_d;
	logic [CW-1:0]   in_use_q, in_use_d;
	logic            init_q, init_d;
	logic            rel_q, rel_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   walk_q, walk_d;
	logic [CW-1:0]   walk_inc;
	logic [CW-1:0]   eff_cnt;
	logic            walk_last;
	logic            accept;

	assign accept    = in_valid && in_ready;
	assign walk_inc  = walk_q + CW'(1);
	assign walk_last = (walk_inc == cnt_q);

	// clamp the configured count into 1..MAX_BLOCKS
	always_comb begin
		if (block_count == '0) begin
			eff_cnt = CW'(1);
		end else if (32'(block_count) > 32'(MAX_BLOCKS)) begin
			eff_cnt = NULL_LINK;
		end else begin
			eff_cnt = CW'(block_count);
		end
	end

	// link read always follows the head; the data is ready in the exec cycle
	assign ram_rd_addr = (head_q == NULL_LINK) ? '0 : head_q[IW-1:0];

	// sequencer and list update
	always_comb begin
		state_d           = state_q;
		head_d            = head_q;
		in_use_d          = in_use_q;
		init_d            = init_q;
		rel_d             = rel_q;
		cnt_d             = cnt_q;
		walk_d            = walk_q;
		in_ready          = 1'b0;
		push              = 1'b0;
		ram_wr_en         = 1'b0;
		ram_wr_addr       = walk_q[IW-1:0];
		ram_wr_data       = walk_last ? NULL_LINK : walk_inc;
		res.status        = STS_OK;
		res.granted_index = '0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (res_ready) begin
					state_d = ST_IDLE;
					push    = 1'b1;
					unique case (act_q)
						ACT_INIT: begin
							if (!init_q) begin
								// start the link walk, result comes at its end
								push    = 1'b0;
								cnt_d   = eff_cnt;
								walk_d  = '0;
								state_d = ST_INIT;
							end
						end
						ACT_ALLOC: begin
							if (rel_q) begin
								res.status = STS_REFUSED;
							end else if (head_q == NULL_LINK || in_use_q >= NULL_LINK) begin
								res.status = STS_EMPTY;
							end else begin
								res.granted_index = INDEX_W'(head_q);
								head_d            = ram_rd_data;
								in_use_d          = in_use_q + CW'(1);
							end
						end
						ACT_FREE: begin
							if (in_use_q == '0 || 32'(idx_q) >= 32'(MAX_BLOCKS)) begin
								res.status = STS_NONE_IN_USE;
							end else begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = IW'(idx_q);
								ram_wr_data = head_q;
								head_d      = CW'(idx_q);
								in_use_d    = in_use_q - CW'(1);
							end
						end
						ACT_RELEASE: begin
							rel_d = 1'b1;
						end
						ACT_TEARDOWN: begin
							rel_d = 1'b1;
							if (in_use_q != '0) begin
								res.status = STS_STILL_USED;
							end else begin
								init_d = 1'b0;
								head_d = NULL_LINK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_INIT: begin
				// one link per cycle; the last one waits for the result slot
				if (!walk_last) begin
					ram_wr_en = 1'b1;
					walk_d    = walk_inc;
				end else if (res_ready) begin
					ram_wr_en = 1'b1;
					push      = 1'b1;
					head_d    = '0;
					init_d    = 1'b1;
					rel_d     = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.used_count = COUNT_W'(in_use_d);
		res.all_free   = (in_use_d == '0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= NULL_LINK;
			in_use_q <= '0;
			init_q   <= 1'b0;
			rel_q    <= 1'b1;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			in_use_q <= in_use_d;
			init_q   <= init_d;
			rel_q    <= rel_d;
		end
	end

	// request capture and walk counters
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(in_action);
			idx_q <= in_index;
		end
		cnt_q  <= cnt_d;
		walk_q <= walk_d;
	end

	// head must hold from the idle read to the exec cycle that uses it
	a_head_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> (head_q == $past(head_q)))
		else $error("head moved while idle");

	// releasing mark only clears when an init walk completes
	a_rel_clear_init: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rel_q) |-> $past(state_q == ST_INIT))
		else $error("releasing cleared outside init");

	// use count stays within the pool
	a_in_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= NULL_LINK)
		else $error("use count above pool size");

	// use count moves only with a delivered result
	a_in_use_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_use_q != $past(in_use_q)) |-> $past(push))
		else $error("use count changed without result");

	// link memory is written only by exec or the init walk
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == ST_EXEC || state_q == ST_INIT))
		else $error("link write outside exec or init");

endmodule

// ===== hw/rtl/fixed_block_free_list_allocator_top.sv =====
// a request is registered, then executed once the output register can take its result;
//   init first writes one link per linked block (the clamped block_count) in a walk
// a new request is taken only once the last result has been handed on, since the
//   link memory read follows the head and the update that uses it comes after it
// reset: empty list, nothing in use, not initialised, releasing set,
//   block_count 1024; the link memory is not cleared
module fixed_block_free_list_allocator_top
	import fbfl_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // block_index[9:0], zero fill
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // granted_index[9:0], used_count[20:10], all_free[21]
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data   // block_count
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	logic [COUNT_W-1:0] block_count_q;
	logic               push;
	logic               res_ready;
	result_t            res;
	result_t            res_q;
	logic               m_tvalid_q;
	logic               ram_wr_en;
	logic [IW-1:0]      ram_wr_addr;
	logic [CW-1:0]      ram_wr_data;
	logic [IW-1:0]      ram_rd_addr;
	logic [CW-1:0]      ram_rd_data;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			block_count_q <= cfg_data;
		end
	end

	fbfl_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_index   (s_tdata[INDEX_W-1:0]),
		.block_count(block_count_q),
		.push       (push),
		.res_ready  (res_ready),
		.res        (res),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data)
	);

	fbfl_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// output register, refilled in the cycle it drains
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {2'b00, res_q.all_free, res_q.used_count, res_q.granted_index};

endmodule

// ===== tb/sv/fbfl_pool_checker.sv =====
`timescale 1ns / 100ps

module fbfl_pool_checker
	import fbfl_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // block_index[9:0], zero fill
	input  logic [2:0]  s_tuser,   // action[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // granted_index[9:0], used_count[20:10], all_free[21]
	input  logic [2:0]  m_tuser,   // status[2:0]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] cfg_data,  // block_count
	output int          error_count,
	output int          pending_results
);

	localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(MAX_BLOCKS);

	// shadow copy of the pool
	logic [COUNT_W-1:0] link_mem [MAX_BLOCKS];
	logic [COUNT_W-1:0] list_head;
	logic [COUNT_W-1:0] used_blocks;
	logic               pool_ready;
	logic               releasing;
	logic [COUNT_W-1:0] block_count;

	result_t expected_q [$];
	int      errors = 0;

	assign error_count = errors;

	task automatic report_error(input string msg);
		$display("%0t fbfl checker: %s", $time, msg);
		errors++;
	endtask

	// work out the result of one request and update the shadow pool
	function automatic result_t pool_step(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx);
		result_t     res;
		int unsigned n;
		int unsigned i;
		res.status        = STS_OK;
		res.granted_index = '0;
		case (act)
			ACT_INIT: begin
				if (!pool_ready) begin
					// zero counts as one, oversize clamps to the pool size
					n = (block_count == 0) ? 1 :
						(block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
					for (i = 0; i + 1 < n; i++)
						link_mem[i] = COUNT_W'(i + 1);
					link_mem[n-1] = NULL_LINK;
					list_head     = '0;
					pool_ready    = 1'b1;
					releasing     = 1'b0;
				end
			end
			ACT_ALLOC: begin
				if (releasing) begin
					res.status = STS_REFUSED;
				end else if (list_head >= NULL_LINK || used_blocks >= NULL_LINK) begin
					res.status = STS_EMPTY;
				end else begin
					res.granted_index = list_head[INDEX_W-1:0];
					list_head         = link_mem[list_head[INDEX_W-1:0]];
					used_blocks++;
				end
			end
			ACT_FREE: begin
				if (used_blocks == 0) begin
					res.status = STS_NONE_IN_USE;
				end else begin
					link_mem[idx] = list_head;
					list_head     = COUNT_W'(idx);
					used_blocks--;
				end
			end
			ACT_RELEASE: begin
				releasing = 1'b1;
			end
			ACT_TEARDOWN: begin
				releasing = 1'b1;
				if (used_blocks != 0) begin
					res.status = STS_STILL_USED;
				end else begin
					pool_ready = 1'b0;
					list_head  = NULL_LINK;
				end
			end
			default: begin
			end
		endcase
		res.used_count = used_blocks;
		res.all_free   = (used_blocks == 0);
		return res;
	endfunction

	// compare one result with the oldest prediction
	task automatic check_result();
		result_t want;
		if (expected_q.size() == 0) begin
			report_error("result with no request pending");
			return;
		end
		want = expected_q.pop_front();
		if (m_tuser != want.status)
			report_error($sformatf("status got %0d expected %0d", m_tuser, want.status));
		if (m_tdata[9:0] != want.granted_index)
			report_error($sformatf("granted_index got %0d expected %0d",
				m_tdata[9:0], want.granted_index));
		if (m_tdata[20:10] != want.used_count)
			report_error($sformatf("used_count got %0d expected %0d",
				m_tdata[20:10], want.used_count));
		if (m_tdata[21] != want.all_free)
			report_error($sformatf("all_free got %0d expected %0d",
				m_tdata[21], want.all_free));
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head       = NULL_LINK;
			used_blocks     = '0;
			pool_ready      = 1'b0;
			releasing       = 1'b1;
			block_count     = COUNT_W'(MAX_BLOCKS);
			expected_q.delete();
			pending_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				block_count = cfg_data;
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				expected_q.push_back(pool_step(s_tuser, s_tdata[INDEX_W-1:0]));
			pending_results <= expected_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_fixed_block_free_list_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator_top;
	import fbfl_pkg::*;

	localparam int unsigned MAX_BLOCKS    = 1024;
	localparam int unsigned HALF_PERIOD   = 10;
	localparam int unsigned RESET_CYCLES  = 9;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned END_CYCLES    = 64;
	localparam longint unsigned TIMEOUT_NS = 20_000_000;
	localparam int unsigned NUM_PHASES    = 9;

	// action codes outside the defined set
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;

	// block_count per random phase, phase 0 in the lowest slot
	localparam logic [NUM_PHASES-1:0][COUNT_W-1:0] PHASE_COUNTS = {
		11'd5, 11'd1023, 11'd2, 11'd1024, 11'd33, 11'd0, 11'd2047, 11'd6, 11'd1
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [15:0] s_tdata   = '0;
	logic [2:0]  s_tuser   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [10:0] cfg_data  = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_ready;

	int                 error_count;
	int                 pending_results;
	int unsigned        sender_idle_pct = 18;
	int unsigned        recv_idle_pct   = 65;
	logic [COUNT_W-1:0] cur_count       = COUNT_W'(MAX_BLOCKS);

	fixed_block_free_list_allocator_top #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	fbfl_pool_checker #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.error_count    (error_count),
		.pending_results(pending_results)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// one request, with random gaps ahead of it
	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= 16'(idx);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold off new requests until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_count(input logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_count  = value;
	endtask

	// mostly allocate and free, frees mostly of blocks inside the pool
	task automatic random_request();
		int unsigned          pick;
		int unsigned          span;
		logic [ACTION_W-1:0]  act;
		logic [INDEX_W-1:0]   idx;
		pick = $urandom_range(0, 99);
		span = (cur_count == 0) ? 1 : (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
		idx  = INDEX_W'($urandom_range(0, MAX_BLOCKS - 1));
		if (pick < 38) begin
			act = ACT_ALLOC;
		end else if (pick < 72) begin
			act = ACT_FREE;
			if ($urandom_range(0, 99) < 85)
				idx = INDEX_W'($urandom_range(0, span - 1));
		end else if (pick < 82) begin
			act = ACT_INIT;
		end else if (pick < 90) begin
			act = ACT_TEARDOWN;
		end else if (pick < 94) begin
			act = ACT_RELEASE;
		end else begin
			act = ACT_UNKNOWN_LO + ACTION_W'($urandom_range(0, 2));
		end
		send_request(act, idx);
	endtask

	function automatic logic [INDEX_W-1:0] rnd_index();
		return INDEX_W'($urandom_range(0, MAX_BLOCKS - 1));
	endfunction

	// stimulus
	initial begin
		int p;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: before init, full-size pool, teardown and release paths
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_FREE, '0);
		send_request(ACT_TEARDOWN, rnd_index());
		send_request(ACT_RELEASE, rnd_index());
		send_request(ACT_UNKNOWN_LO, '1);
		send_request(ACT_UNKNOWN_HI, '0);
		send_request(ACT_INIT, rnd_index());
		send_request(ACT_INIT, rnd_index());
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_FREE, '1);
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_TEARDOWN, rnd_index());
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_FREE, '0);
		send_request(ACT_FREE, '1);
		send_request(ACT_FREE, '1);
		// init on a live pool leaves releasing set
		send_request(ACT_INIT, rnd_index());
		send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_TEARDOWN, rnd_index());

		// two-block pool: empty list, then a double free makes the list cyclic
		// and allocation keeps handing out the same block
		drain_results();
		write_block_count(11'd2);
		send_request(ACT_INIT, rnd_index());
		repeat (3) send_request(ACT_ALLOC, rnd_index());
		repeat (2) send_request(ACT_FREE, '0);
		repeat (8) send_request(ACT_ALLOC, rnd_index());
		send_request(ACT_TEARDOWN, rnd_index());
		repeat (8) send_request(ACT_FREE, rnd_index());
		send_request(ACT_FREE, rnd_index());
		send_request(ACT_TEARDOWN, rnd_index());

		// random phases, three settings per idling mode
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p / 3)
				0: begin
					sender_idle_pct = 18;
					recv_idle_pct   = 65;
				end
				1: begin
					sender_idle_pct = 65;
					recv_idle_pct   = 18;
				end
				default: begin
					sender_idle_pct = 0;
					recv_idle_pct   = 0;
				end
			endcase
			drain_results();
			write_block_count(PHASE_COUNTS[p]);
			repeat ((PHASE_COUNTS[p] >= 1000) ? 30 : 105) random_request();
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results == 0) begin
			$display("tb_fixed_block_free_list_allocator_top passed");
		end else begin
			$display("tb_fixed_block_free_list_allocator_top failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("tb_fixed_block_free_list_allocator_top failed");
		$finish;
	end

endmodule
